FILE: design/grapheme_cluster_segmenter_macros.svh
// Assertion helpers shared by the checker files.
`ifndef GRAPHEME_CLUSTER_SEGMENTER_MACROS_SVH
`define GRAPHEME_CLUSTER_SEGMENTER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define GCS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define GCS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/gcs_pkg.sv
package gcs_pkg;

	localparam int POSITION_BITS = 24;
	localparam int COUNT_BITS = 8;
	localparam int CLASS_BITS = 6;
	localparam int KIND_BITS = 4;
	localparam int WIDTH_BITS = 2;
	localparam int CFG_ADDR_BITS = 3;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

	typedef enum logic [KIND_BITS-1:0] {
		BK_OTHER = 4'd0,
		BK_CR = 4'd1,
		BK_LF = 4'd2,
		BK_CONTROL = 4'd3,
		BK_EXTEND = 4'd4,
		BK_SPACINGMARK = 4'd5,
		BK_PREPEND = 4'd6,
		BK_L = 4'd7,
		BK_V = 4'd8,
		BK_T = 4'd9,
		BK_LV = 4'd10,
		BK_LVT = 4'd11
	} break_kind_t;

	typedef enum logic [WIDTH_BITS-1:0] {
		WK_NARROW = 2'd0,
		WK_FULL = 2'd1,
		WK_WIDE = 2'd2,
		WK_ZERO = 2'd3
	} width_kind_t;

	typedef enum logic [CFG_ADDR_BITS-1:0] {
		CFG_SPACE = 3'd0,
		CFG_SOUTH_ASIAN = 3'd1,
		CFG_COMBINING = 3'd2,
		CFG_ALPHABETIC = 3'd3,
		CFG_KEEP_THAI = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [KIND_BITS-1:0] break_kind;
		logic [WIDTH_BITS-1:0] width_kind;
		logic [CLASS_BITS-1:0] line_class;
		logic script_is_thai;
		logic end_of_string;
	} item_t;

	typedef struct packed {
		logic [POSITION_BITS-1:0] cluster_start;
		logic [COUNT_BITS-1:0] cluster_length;
		logic [COUNT_BITS-1:0] cluster_columns;
		logic [CLASS_BITS-1:0] cluster_line_class;
		logic string_done;
	} result_t;

endpackage

FILE: design/gcs_ifs.sv
interface gcs_cp_if;
	import gcs_pkg::*;

	logic valid;
	logic ready;
	logic [KIND_BITS-1:0] break_kind;
	logic [WIDTH_BITS-1:0] width_kind;
	logic [CLASS_BITS-1:0] line_class;
	logic script_is_thai;
	logic end_of_string;

	modport source (
		output valid, break_kind, width_kind, line_class, script_is_thai, end_of_string,
		input ready
	);
	modport sink (
		input valid, break_kind, width_kind, line_class, script_is_thai, end_of_string,
		output ready
	);
endinterface

interface gcs_cl_if;
	import gcs_pkg::*;

	logic valid;
	logic ready;
	logic [POSITION_BITS-1:0] cluster_start;
	logic [COUNT_BITS-1:0] cluster_length;
	logic [COUNT_BITS-1:0] cluster_columns;
	logic [CLASS_BITS-1:0] cluster_line_class;
	logic string_done;

	modport source (
		output valid, cluster_start, cluster_length, cluster_columns, cluster_line_class,
		output string_done,
		input ready
	);
	modport sink (
		input valid, cluster_start, cluster_length, cluster_columns, cluster_line_class,
		input string_done,
		output ready
	);
endinterface

interface gcs_cfg_if;
	import gcs_pkg::*;

	logic valid;
	logic ready;
	logic [CFG_ADDR_BITS-1:0] addr;
	logic [CLASS_BITS-1:0] data;

	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

FILE: design/grapheme_cluster_segmenter.sv
// Grapheme cluster segmenter. Takes one classified code point per cycle on
// code_point and reports each finished grapheme cluster on cluster: start
// index, length, display columns and line break class (SA remapped). A
// cluster is reported when the next code point opens a new one or when the
// end-of-string mark arrives; one code point can release two clusters. Each
// code point is held in the input register and is then folded into the
// open-cluster state, writing its results into a four-entry result queue.
// Sustained rate is one code point per cycle while the result side keeps up;
// input stalls only when fewer than two queue entries are free. A result is
// written into the queue as the code point that releases it is folded in.
// Configuration is on cfg, always ready; the user must write it only while
// idle, which the block itself does not enforce.
module grapheme_cluster_segmenter (
	input logic clk,
	input logic arst_n,
	gcs_cp_if.sink code_point,
	gcs_cl_if.source cluster,
	gcs_cfg_if.sink cfg
);
	import gcs_pkg::*;

	typedef struct packed {
		logic [POSITION_BITS-1:0] start;
		logic [COUNT_BITS-1:0] length;
		logic [KIND_BITS-1:0] prior;
		logic [KIND_BITS-1:0] head;
		logic [CLASS_BITS-1:0] line;
		logic thai;
		logic [COUNT_BITS-1:0] base;
		logic [COUNT_BITS-1:0] prep;
		logic [COUNT_BITS-1:0] ext;
	} open_t;

	function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
			input logic [COUNT_BITS-1:0] b);
		logic [COUNT_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
	endfunction

	function automatic logic hangul_joins(input logic [KIND_BITS-1:0] p,
			input logic [KIND_BITS-1:0] n);
		logic r;
		case (p)
			BK_L: r = (n == BK_L) || (n == BK_V) || (n == BK_LV) || (n == BK_LVT);
			BK_LV, BK_V: r = (n == BK_V) || (n == BK_T);
			BK_LVT, BK_T: r = (n == BK_T);
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic result_t emit(input open_t st, input logic done,
			input logic [CLASS_BITS-1:0] sa_code, input logic [CLASS_BITS-1:0] cm_code,
			input logic [CLASS_BITS-1:0] al_code, input logic keep_thai);
		result_t r;
		r.cluster_start = st.start;
		r.cluster_length = st.length;
		r.cluster_columns = sat_add(sat_add(st.base, st.prep), st.ext);
		r.cluster_line_class = st.line;
		if ((st.line == sa_code) && !(keep_thai && st.thai)) begin
			r.cluster_line_class = ((st.head == BK_EXTEND) || (st.head == BK_SPACINGMARK)) ?
				cm_code : al_code;
		end
		r.string_done = done;
		return r;
	endfunction

	// configuration
	logic [CLASS_BITS-1:0] space_code_q;
	logic [CLASS_BITS-1:0] sa_code_q;
	logic [CLASS_BITS-1:0] cm_code_q;
	logic [CLASS_BITS-1:0] al_code_q;
	logic keep_thai_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			space_code_q <= CLASS_BITS'(0);
			sa_code_q <= CLASS_BITS'(1);
			cm_code_q <= CLASS_BITS'(2);
			al_code_q <= CLASS_BITS'(3);
			keep_thai_q <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.addr))
				CFG_SPACE: space_code_q <= cfg.data;
				CFG_SOUTH_ASIAN: sa_code_q <= cfg.data;
				CFG_COMBINING: cm_code_q <= cfg.data;
				CFG_ALPHABETIC: al_code_q <= cfg.data;
				CFG_KEEP_THAI: keep_thai_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// input register
	logic valid_s1;
	item_t item_s1;
	logic [FIFO_PTR_BITS:0] cnt_q;
	logic proc;

	assign proc = valid_s1 && (cnt_q <= (FIFO_PTR_BITS + 1)'(FIFO_DEPTH - 2));
	assign code_point.ready = !valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (code_point.ready) begin
			valid_s1 <= code_point.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (code_point.ready) begin
			item_s1.break_kind <= code_point.break_kind;
			item_s1.width_kind <= code_point.width_kind;
			item_s1.line_class <= code_point.line_class;
			item_s1.script_is_thai <= code_point.script_is_thai;
			item_s1.end_of_string <= code_point.end_of_string;
		end
	end

	// open-cluster state
	open_t st_q, st_d;
	logic open_q, open_d;
	logic closed_q, closed_d;
	logic [POSITION_BITS-1:0] pos_q, pos_d;
	logic [KIND_BITS-1:0] bk;
	logic [COUNT_BITS-1:0] col;
	logic joined;
	logic emit_a;
	result_t res_a, res_b, first, second;
	logic [1:0] npush;

	always_comb begin
		bk = (item_s1.break_kind > BK_LVT) ? BK_OTHER : item_s1.break_kind;
		case (item_s1.width_kind)
			WK_FULL, WK_WIDE: col = COUNT_BITS'(2);
			WK_ZERO: col = COUNT_BITS'(0);
			default: col = COUNT_BITS'(1);
		endcase

		st_d = st_q;
		open_d = open_q;
		closed_d = closed_q;
		joined = 1'b0;

		if (open_q && !closed_q) begin
			if (st_q.prior == BK_CR) begin
				if (bk == BK_LF) begin
					joined = 1'b1;
					st_d.base = sat_add(st_q.base, col);
					closed_d = 1'b1;
				end
			end else if ((bk == BK_CONTROL) || (bk == BK_CR) || (bk == BK_LF)) begin
				joined = 1'b0;
			end else if (hangul_joins(st_q.prior, bk)) begin
				joined = 1'b1;
				st_d.base = COUNT_BITS'(2);
				st_d.prior = bk;
			end else if ((bk == BK_EXTEND) || (bk == BK_SPACINGMARK)) begin
				joined = 1'b1;
				st_d.ext = sat_add(st_q.ext, col);
			end else if (st_q.prior == BK_PREPEND) begin
				joined = 1'b1;
				st_d.line = item_s1.line_class;
				st_d.head = bk;
				st_d.thai = item_s1.script_is_thai;
				st_d.prep = sat_add(st_q.prep, st_q.base);
				st_d.base = col;
				st_d.prior = bk;
			end
		end

		emit_a = !joined && open_q;
		if (joined) begin
			st_d.length = sat_add(st_q.length, COUNT_BITS'(1));
		end else begin
			open_d = 1'b1;
			st_d.start = pos_q;
			st_d.length = COUNT_BITS'(1);
			st_d.prior = bk;
			st_d.head = bk;
			st_d.line = item_s1.line_class;
			st_d.thai = item_s1.script_is_thai;
			st_d.base = col;
			st_d.prep = COUNT_BITS'(0);
			st_d.ext = COUNT_BITS'(0);
			closed_d = (bk == BK_LF) || (bk == BK_CONTROL) ||
				((bk != BK_CR) && (item_s1.line_class == space_code_q));
		end
		pos_d = pos_q + POSITION_BITS'(1);

		res_a = emit(st_q, 1'b0, sa_code_q, cm_code_q, al_code_q, keep_thai_q);
		res_b = emit(st_d, 1'b1, sa_code_q, cm_code_q, al_code_q, keep_thai_q);

		if (item_s1.end_of_string) begin
			open_d = 1'b0;
			closed_d = 1'b0;
			pos_d = POSITION_BITS'(0);
		end

		first = emit_a ? res_a : res_b;
		second = res_b;
		npush = proc ? (2'(emit_a) + 2'(item_s1.end_of_string)) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
			open_q <= 1'b0;
			closed_q <= 1'b0;
			pos_q <= '0;
		end else if (proc) begin
			st_q <= st_d;
			open_q <= open_d;
			closed_q <= closed_d;
			pos_q <= pos_d;
		end
	end

	// result queue
	result_t fifo_q [FIFO_DEPTH];
	logic [FIFO_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic pop;
	result_t head_res;

	assign pop = cluster.valid && cluster.ready;
	assign head_res = fifo_q[rd_ptr_q];
	assign cluster.valid = (cnt_q != '0);
	assign cluster.cluster_start = head_res.cluster_start;
	assign cluster.cluster_length = head_res.cluster_length;
	assign cluster.cluster_columns = head_res.cluster_columns;
	assign cluster.cluster_line_class = head_res.cluster_line_class;
	assign cluster.string_done = head_res.string_done;

	always_ff @(posedge clk) begin
		if (npush != 2'd0) begin
			fifo_q[wr_ptr_q] <= first;
		end
		if (npush == 2'd2) begin
			fifo_q[wr_ptr_q + FIFO_PTR_BITS'(1)] <= second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_BITS'(npush);
			rd_ptr_q <= rd_ptr_q + FIFO_PTR_BITS'(pop);
			cnt_q <= cnt_q + (FIFO_PTR_BITS + 1)'(npush) - (FIFO_PTR_BITS + 1)'(pop);
		end
	end

endmodule

FILE: design/gcs_checker.sv
`include "grapheme_cluster_segmenter_macros.svh"

module gcs_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [gcs_pkg::POSITION_BITS-1:0] cluster_start,
	input logic [gcs_pkg::COUNT_BITS-1:0] cluster_length,
	input logic string_done
);
	import gcs_pkg::*;

	`GCS_ASSERT_NOW(a_len_nonzero, out_valid, cluster_length != '0, "empty cluster reported")
	`GCS_ASSERT_NEXT(a_new_string_at_zero, out_valid && out_ready && string_done, !out_valid || (cluster_start == '0), "cluster after string end not at index zero")
	`GCS_ASSERT_NEXT(a_valid_holds, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`GCS_ASSERT_NEXT(a_payload_holds, out_valid && !out_ready, $stable(cluster_start) && $stable(cluster_length), "stalled result changed")

endmodule

bind grapheme_cluster_segmenter gcs_checker u_gcs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(cluster.valid),
	.out_ready(cluster.ready),
	.cluster_start(cluster.cluster_start),
	.cluster_length(cluster.cluster_length),
	.string_done(cluster.string_done)
);
